// ----- design/xgb_pkg.sv -----
// xgb_pkg: shared constants and types for the xoshiro256+ generator bank.
// No dependencies; used by xoshiro256plus_generator_bank_top.
`timescale 1ns / 1ps

package xgb_pkg;

  // Bank geometry
  localparam int GENERATORS = 256;
  localparam int INT_BITS   = 15;
  localparam int IDX_W      = (GENERATORS > 1) ? $clog2(GENERATORS) : 1;
  localparam int ROW_W      = 256;

  // Seeding LCG
  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_INC = 32'd2531011;

  // splitmix64 constants
  localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX1   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX2   = 64'h94D0_49BB_1331_11EB;

  // xoshiro256+ shift and rotate amounts
  localparam int ROT_AMT = 45;
  localparam int T_SHIFT = 17;

  // Command codes
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_LCG_MUL,
    ST_LCG_ADD,
    ST_MIX_LOAD,
    ST_MUL
  } state_e;

endpackage

// ----- design/xoshiro256plus_generator_bank_top.sv -----
// xoshiro256plus_generator_bank_top: bank of xoshiro256+ generators, round-robin draws.
// Depends on xgb_pkg for constants and the sequencer state type.
`timescale 1ns / 1ps

// A command beat is taken when start is high and busy is low. In a draw (func_i = 1)
// the accept cycle reads the next generator's row from the bank memory and the
// following cycle steps it and writes it back; the result is on
// raw_word_o/masked_int_o for one cycle, with result_valid_o high, in the cycle after
// that, and busy is already low then, so the next draw can be taken in that cycle.
// The receiver cannot stall results. A reseed (func_i = 0) gives no result and keeps
// busy high while it refills every generator (4 LCG steps, then 4 splitmix words,
// both multiplies of a word going through one shared 32x32 multiplier as three
// partial products). Before the first reseed every draw returns zero.
module xoshiro256plus_generator_bank_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic signed [31:0]              seed_value_i,
  output logic                            result_valid_o,
  output logic [31:0]                     raw_word_o,
  output logic [xgb_pkg::INT_BITS-1:0]    masked_int_o
);

  localparam int IW = xgb_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(xgb_pkg::GENERATORS - 1);

  // Control registers
  xgb_pkg::state_e state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   gen_q, gen_d;
  logic [1:0]      lcg_cnt_q, lcg_cnt_d;
  logic [1:0]      word_cnt_q, word_cnt_d;
  logic [1:0]      phase_q, phase_d;
  logic            round_q, round_d;
  logic            bank_valid_q, bank_valid_d;
  logic            res_valid_q, res_valid_d;

  // Datapath registers
  logic [31:0]     lcg_q, lcg_d;
  logic [63:0]     sm_q, sm_d;
  logic [63:0]     z_q, z_d;
  logic [63:0]     acc_q, acc_d;
  logic [63:0]     prod_q;
  logic [63:0]     w_q [3];
  logic [63:0]     w_d [3];
  logic [31:0]     raw_q, raw_d;

  // Bank memory, one row per generator: {s3, s2, s1, s0}
  logic [xgb_pkg::ROW_W-1:0] mem [xgb_pkg::GENERATORS];
  logic [xgb_pkg::ROW_W-1:0] rd_q;
  logic [xgb_pkg::ROW_W-1:0] wr_row;
  logic [IW-1:0]             rd_addr;
  logic [IW-1:0]             wr_addr;
  logic                      wr_en;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_d;

  logic        accept;
  logic [IW-1:0] idx_next;

  // Draw step datapath
  logic [63:0] s0, s1, s2, s3, t_w, n0, n1, n2, n3, n3r;
  logic [255:0] cur_row;

  // Multiply tail
  logic [63:0] mix_k, mul_res, mix_out;
  logic [31:0] lcg_new;
  logic [63:0] z_fold;

  assign accept   = start && !busy;
  assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign prod_d   = mul_a * mul_b;

  // Rows not yet seeded read as zero state
  assign cur_row = bank_valid_q ? rd_q : '0;
  assign s0 = cur_row[63:0];
  assign s1 = cur_row[127:64];
  assign s2 = cur_row[191:128];
  assign s3 = cur_row[255:192];

  // xoshiro256+ state update
  always_comb begin
    t_w = s1 << xgb_pkg::T_SHIFT;
    n2  = s2 ^ s0;
    n3  = s3 ^ s1;
    n1  = s1 ^ n2;
    n0  = s0 ^ n3;
    n3r = (n3 << xgb_pkg::ROT_AMT) | (n3 >> (64 - xgb_pkg::ROT_AMT));
  end

  assign mix_k   = round_q ? xgb_pkg::MIX2 : xgb_pkg::MIX1;
  assign mul_res = acc_q + {prod_q[31:0], 32'h0};
  assign mix_out = mul_res ^ (mul_res >> 31);
  assign lcg_new = prod_q[31:0] + xgb_pkg::LCG_INC;
  assign z_fold  = sm_q ^ (sm_q >> 30);

  // Next state, multiplier operands and memory control
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    gen_d        = gen_q;
    lcg_cnt_d    = lcg_cnt_q;
    word_cnt_d   = word_cnt_q;
    phase_d      = phase_q;
    round_d      = round_q;
    bank_valid_d = bank_valid_q;
    res_valid_d  = 1'b0;
    lcg_d        = lcg_q;
    sm_d         = sm_q;
    z_d          = z_q;
    acc_d        = acc_q;
    raw_d        = raw_q;
    w_d          = w_q;
    mul_a        = lcg_q;
    mul_b        = xgb_pkg::LCG_MUL;
    rd_addr      = idx_q;
    wr_addr      = idx_q;
    wr_en        = 1'b0;
    wr_row       = {n3r, n2 ^ t_w, n1, n0};

    case (state_q)
      xgb_pkg::ST_IDLE: begin
        rd_addr = idx_next;
        if (accept) begin
          if (func_i == xgb_pkg::FUNC_DRAW) begin
            idx_d   = idx_next;
            state_d = xgb_pkg::ST_DRAW;
          end else begin
            lcg_d     = seed_value_i;
            idx_d     = '0;
            gen_d     = '0;
            lcg_cnt_d = '0;
            state_d   = xgb_pkg::ST_LCG_MUL;
          end
        end
      end

      // Row is in rd_q: step it, write back, register the result
      xgb_pkg::ST_DRAW: begin
        wr_en       = 1'b1;
        raw_d       = s0[31:0] + s3[31:0];
        res_valid_d = 1'b1;
        state_d     = xgb_pkg::ST_IDLE;
      end

      xgb_pkg::ST_LCG_MUL: begin
        state_d = xgb_pkg::ST_LCG_ADD;
      end

      // Finish the LCG step, shift its top half into the seed
      xgb_pkg::ST_LCG_ADD: begin
        lcg_d     = lcg_new;
        sm_d      = {sm_q[47:0], lcg_new[31:16]};
        lcg_cnt_d = lcg_cnt_q + 1'b1;
        if (lcg_cnt_q == 2'd3) begin
          word_cnt_d = '0;
          state_d    = xgb_pkg::ST_MIX_LOAD;
        end else begin
          state_d = xgb_pkg::ST_LCG_MUL;
        end
      end

      xgb_pkg::ST_MIX_LOAD: begin
        z_d     = z_fold;
        sm_d    = sm_q + xgb_pkg::GOLDEN;
        round_d = 1'b0;
        phase_d = '0;
        state_d = xgb_pkg::ST_MUL;
      end

      // 64x64 low product as three 32x32 partial products
      xgb_pkg::ST_MUL: begin
        phase_d = phase_q + 1'b1;
        case (phase_q)
          2'd0: begin
            mul_a = z_q[31:0];
            mul_b = mix_k[31:0];
          end
          2'd1: begin
            mul_a = z_q[31:0];
            mul_b = mix_k[63:32];
            acc_d = prod_q;
          end
          2'd2: begin
            mul_a = z_q[63:32];
            mul_b = mix_k[31:0];
            acc_d = mul_res;
          end
          default: begin
            if (!round_q) begin
              z_d     = mul_res ^ (mul_res >> 27);
              round_d = 1'b1;
            end else if (word_cnt_q != 2'd3) begin
              w_d[word_cnt_q] = mix_out;
              word_cnt_d      = word_cnt_q + 1'b1;
              state_d         = xgb_pkg::ST_MIX_LOAD;
            end else begin
              wr_en   = 1'b1;
              wr_addr = gen_q;
              wr_row  = {mix_out, w_q[2], w_q[1], w_q[0]};
              if (gen_q == LAST_IDX) begin
                bank_valid_d = 1'b1;
                state_d      = xgb_pkg::ST_IDLE;
              end else begin
                gen_d     = gen_q + 1'b1;
                lcg_cnt_d = '0;
                state_d   = xgb_pkg::ST_LCG_MUL;
              end
            end
          end
        endcase
      end

      default: begin
        state_d = xgb_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= xgb_pkg::ST_IDLE;
      idx_q        <= '0;
      gen_q        <= '0;
      lcg_cnt_q    <= '0;
      word_cnt_q   <= '0;
      phase_q      <= '0;
      round_q      <= 1'b0;
      bank_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      lcg_q        <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      gen_q        <= gen_d;
      lcg_cnt_q    <= lcg_cnt_d;
      word_cnt_q   <= word_cnt_d;
      phase_q      <= phase_d;
      round_q      <= round_d;
      bank_valid_q <= bank_valid_d;
      res_valid_q  <= res_valid_d;
      lcg_q        <= lcg_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sm_q   <= sm_d;
    z_q    <= z_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    w_q    <= w_d;
    raw_q  <= raw_d;
  end

  // Bank memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_q <= mem[rd_addr];
  end

  assign busy           = (state_q != xgb_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign raw_word_o     = raw_q;
  assign masked_int_o   = raw_q[xgb_pkg::INT_BITS-1:0];

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for xoshiro256plus_generator_bank_top.
// Depends on xgb_pkg and the top level. Reseeds and draws are predicted
// in-bench and every result beat is compared in order of issue.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 1630;
  localparam int STALL_LIMIT  = 50000;  // longer than a whole reseed, which gives no beats
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;

  // Clock, reset and block ports
  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start          = 1'b0;
  logic                         func_i         = xgb_pkg::FUNC_DRAW;
  logic [31:0]                  seed_value_i   = '0;
  logic                         busy;
  logic                         result_valid_o;
  logic [31:0]                  raw_word_o;
  logic [xgb_pkg::INT_BITS-1:0] masked_int_o;

  xoshiro256plus_generator_bank_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .seed_value_i   (seed_value_i),
    .result_valid_o (result_valid_o),
    .raw_word_o     (raw_word_o),
    .masked_int_o   (masked_int_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Expected draws, oldest first
  typedef struct {
    logic [31:0]                  raw;
    logic [xgb_pkg::INT_BITS-1:0] masked;
  } draw_t;

  draw_t pending_draws[$];
  int    mismatches = 0;

  // Bank model
  logic [63:0] bank_s0 [xgb_pkg::GENERATORS];
  logic [63:0] bank_s1 [xgb_pkg::GENERATORS];
  logic [63:0] bank_s2 [xgb_pkg::GENERATORS];
  logic [63:0] bank_s3 [xgb_pkg::GENERATORS];
  logic [31:0] lcg_word = '0;
  int unsigned gen_sel  = 0;

  initial begin
    for (int g = 0; g < xgb_pkg::GENERATORS; g++) begin
      bank_s0[g] = '0;
      bank_s1[g] = '0;
      bank_s2[g] = '0;
      bank_s3[g] = '0;
    end
  end

  function automatic logic [15:0] lcg_advance();
    lcg_word = lcg_word * xgb_pkg::LCG_MUL + xgb_pkg::LCG_INC;
    return lcg_word[31:16];
  endfunction

  function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
    logic [63:0] y;
    y = (z ^ (z >> 30)) * xgb_pkg::MIX1;
    y = (y ^ (y >> 27)) * xgb_pkg::MIX2;
    return y ^ (y >> 31);
  endfunction

  // Refill every generator: four LCG outputs, first one on top, then splitmix
  task automatic reseed_bank_model(input logic [31:0] seed);
    logic [63:0] sm;
    lcg_word = seed;
    gen_sel  = 0;
    for (int g = 0; g < xgb_pkg::GENERATORS; g++) begin
      sm = '0;
      repeat (4) sm = {sm[47:0], lcg_advance()};
      bank_s0[g] = splitmix_mix(sm);
      sm += xgb_pkg::GOLDEN;
      bank_s1[g] = splitmix_mix(sm);
      sm += xgb_pkg::GOLDEN;
      bank_s2[g] = splitmix_mix(sm);
      sm += xgb_pkg::GOLDEN;
      bank_s3[g] = splitmix_mix(sm);
    end
  endtask

  // Advance the index, then step that generator; the word comes from the old state
  function automatic logic [31:0] draw_model();
    logic [63:0] s0, s1, s2, s3, t;
    logic [63:0] sum;
    gen_sel = (gen_sel + 1 >= xgb_pkg::GENERATORS) ? 0 : gen_sel + 1;
    s0  = bank_s0[gen_sel];
    s1  = bank_s1[gen_sel];
    s2  = bank_s2[gen_sel];
    s3  = bank_s3[gen_sel];
    sum = s0 + s3;
    t   = s1 << xgb_pkg::T_SHIFT;
    s2 ^= s0;
    s3 ^= s1;
    s1 ^= s2;
    s0 ^= s3;
    s2 ^= t;
    s3 = (s3 << xgb_pkg::ROT_AMT) | (s3 >> (64 - xgb_pkg::ROT_AMT));
    bank_s0[gen_sel] = s0;
    bank_s1[gen_sel] = s1;
    bank_s2[gen_sel] = s2;
    bank_s3[gen_sel] = s3;
    return sum[31:0];
  endfunction

  // Directed stimulus; typed expectations only where the bank is still all zero
  typedef struct {
    logic                         func;
    logic [31:0]                  seed;
    bit                           typed;
    logic [31:0]                  raw;
    logic [xgb_pkg::INT_BITS-1:0] masked;
  } op_row_t;

  localparam int DIRECTED_ROWS = 21;

  op_row_t directed_ops [DIRECTED_ROWS] = '{
    // draws before any reseed: zero state gives zero
    '{xgb_pkg::FUNC_DRAW, 32'hFFFF_FFFF, 1'b1, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b1, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h8000_0000, 1'b1, 32'h0, '0},
    // zero seed; first draw lands on generator 1
    '{xgb_pkg::FUNC_SEED, 32'h0000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h5555_5555, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'hAAAA_AAAA, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0},
    // seed extremes
    '{xgb_pkg::FUNC_SEED, 32'hFFFF_FFFF, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'hFFFF_FFFF, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_SEED, 32'h7FFF_FFFF, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_SEED, 32'h8000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h7FFF_FFFF, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h8000_0000, 1'b0, 32'h0, '0},
    // back-to-back reseeds: only the second one counts
    '{xgb_pkg::FUNC_SEED, 32'h1234_5678, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_SEED, 32'h0000_0001, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0},
    '{xgb_pkg::FUNC_DRAW, 32'h0000_0000, 1'b0, 32'h0, '0}
  };

  bit no_idle = 1'b0;

  // Present one command beat, wait for it to be taken, then predict it
  task automatic issue_command(input logic func, input logic [31:0] seed,
                               input bit typed, input logic [31:0] typed_raw,
                               input logic [xgb_pkg::INT_BITS-1:0] typed_masked);
    int          gap;
    logic [31:0] word;
    draw_t       exp_draw;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= func;
    seed_value_i <= seed;
    do @(posedge clk_i); while (busy);
    if (func == xgb_pkg::FUNC_SEED) begin
      reseed_bank_model(seed);
    end else begin
      word = draw_model();
      if (typed) begin
        exp_draw.raw    = typed_raw;
        exp_draw.masked = typed_masked;
      end else begin
        exp_draw.raw    = word;
        exp_draw.masked = word[xgb_pkg::INT_BITS-1:0];
      end
      pending_draws.push_back(exp_draw);
    end
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    int issued;
    int seg_len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i]) begin
      no_idle = ($urandom_range(0, 3) == 0);
      issue_command(directed_ops[i].func, directed_ops[i].seed, directed_ops[i].typed,
                    directed_ops[i].raw, directed_ops[i].masked);
    end

    // Reseed, then a run of draws; long runs wrap the generator index
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 450);
      no_idle = ($urandom_range(0, 3) == 0);
      issue_command(xgb_pkg::FUNC_SEED, pick_seed(), 1'b0, '0, '0);
      issued++;
      for (int i = 0; i < seg_len && issued < RANDOM_ITEMS; i++) begin
        if ((i % 64) == 63) no_idle = ($urandom_range(0, 3) == 0);
        issue_command(xgb_pkg::FUNC_DRAW, $urandom, 1'b0, '0, '0);
        issued++;
      end
    end
    start <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result checker: the receiver never stalls, so every strobe is a beat
  always @(posedge clk_i) begin
    draw_t exp_draw;
    if (rst_ni && result_valid_o) begin
      if (pending_draws.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: unexpected result beat raw=%h masked=%h",
                   $realtime, raw_word_o, masked_int_o);
        mismatches++;
      end else begin
        exp_draw = pending_draws.pop_front();
        if (raw_word_o !== exp_draw.raw || masked_int_o !== exp_draw.masked) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: result mismatch raw exp=%h got=%h, masked exp=%h got=%h",
                     $realtime, exp_draw.raw, raw_word_o, exp_draw.masked, masked_int_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without a command or result beat
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
design/xgb_pkg.sv
design/xoshiro256plus_generator_bank_top.sv
bench/tb.sv
